@@ sv/lgt_pkg.sv @@
// lgt_pkg: shared constants, codes and beat types of the lane gap tracker
// no dependencies; imported by every module of the block

package lgt_pkg;

   // geometry and field widths
   localparam int LANE_COUNT  = 3;
   localparam int LANE_WIDTH  = 256;
   localparam int POS_W       = 20;
   localparam int OFS_W       = 12;
   localparam int SPD_W       = 12;
   localparam int LANE_IDX_W  = 2;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 20;

   // register reset values
   localparam logic [POS_W-1:0] TRACK_LENGTH_RST    = 20'd444515;
   localparam logic [POS_W-1:0] LANE_CHANGE_GAP_RST = 20'd1920;
   localparam logic [SPD_W-1:0] SPEED_LIMIT_RST     = 12'd1416;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRACK_LENGTH    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LANE_CHANGE_GAP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT     = 2'd2;

   // lane codes
   localparam logic [LANE_IDX_W-1:0] LANE_LEFT   = 2'd0;
   localparam logic [LANE_IDX_W-1:0] LANE_MIDDLE = 2'd1;
   localparam logic [LANE_IDX_W-1:0] LANE_RIGHT  = 2'd2;

   // configuration register file
   typedef struct packed {
      logic [POS_W-1:0] track_length;
      logic [POS_W-1:0] lane_change_gap;
      logic [SPD_W-1:0] speed_limit;
   } csr_type;

   // one input beat as captured
   typedef struct packed {
      logic [POS_W-1:0]        ego_position;
      logic signed [OFS_W-1:0] ego_offset;
      logic [POS_W-1:0]        car_position;
      logic signed [OFS_W-1:0] car_offset;
      logic [SPD_W-1:0]        car_speed;
      logic                    car_present;
      logic                    first_of_frame;
      logic                    last_of_frame;
   } item_type;

   // ring distance and lane match, ready for the minimum update
   typedef struct packed {
      logic [LANE_COUNT-1:0] hit;
      logic                  ahead;
      logic [POS_W-1:0]      gap;
      logic [SPD_W-1:0]      speed;
      logic [LANE_IDX_W-1:0] own_lane;
      logic                  first;
      logic                  last;
   } slot_type;

   // one result beat
   typedef struct packed {
      logic [LANE_COUNT-1:0][POS_W-1:0] ahead_gap;
      logic [LANE_COUNT-1:0][POS_W-1:0] behind_gap;
      logic [LANE_COUNT-1:0][SPD_W-1:0] ahead_speed;
      logic [LANE_IDX_W-1:0]            own_lane;
      logic                             move_left_ok;
      logic                             move_right_ok;
   } result_type;

endpackage

@@ sv/lgt_dist.sv @@
// lgt_dist: input register, ring distance, ahead/behind choice and lane match
// depends on lgt_pkg; feeds lgt_lanes through a registered slot

module lgt_dist (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [lgt_pkg::POS_W-1:0] track_length,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  lgt_pkg::item_type       req_item,
   output logic                    slot_valid,
   output lgt_pkg::slot_type       slot,
   input  logic                    slot_take
);
   import lgt_pkg::*;

   logic     in_valid_ff, in_valid_in;
   item_type in_ff;
   logic     slot_valid_ff, slot_valid_in;
   slot_type slot_ff, slot_in;
   logic     slot_free, in_go, in_free;

   logic [POS_W-1:0] diff, adj, len;
   logic             car_ge, car_le, wrap;

   // stall chain back from the lane stage
   assign slot_free   = !slot_valid_ff || slot_take;
   assign in_go       = in_valid_ff && slot_free;
   assign in_free     = !in_valid_ff || in_go;
   assign req_stall   = !in_free;
   assign in_valid_in = req_valid ? 1'b1 : (in_go ? 1'b0 : in_valid_ff);
   assign slot_valid_in = in_go ? 1'b1 : (slot_take ? 1'b0 : slot_valid_ff);

   // ring distance: shorter way round, tie takes the wrapped way
   always_comb begin
      len    = track_length;
      car_ge = in_ff.car_position >= in_ff.ego_position;
      car_le = in_ff.car_position <= in_ff.ego_position;
      diff   = car_ge ? in_ff.car_position - in_ff.ego_position
                      : in_ff.ego_position - in_ff.car_position;
      adj    = (diff >= len) ? diff - len : len - diff;
      wrap   = adj <= diff;

      slot_in       = '0;
      slot_in.gap   = wrap ? adj : diff;
      if (wrap) begin
         slot_in.ahead = car_le ? (len >= diff) : (diff >= len);
      end else begin
         slot_in.ahead = car_ge;
      end
      slot_in.speed = in_ff.car_speed;
      slot_in.first = in_ff.first_of_frame;
      slot_in.last  = in_ff.last_of_frame;

      // lane match, boundaries excluded
      for (int l = 0; l < LANE_COUNT; l++) begin
         slot_in.hit[l] = in_ff.car_present
            && (in_ff.car_offset > $signed(OFS_W'(LANE_WIDTH * l)))
            && (in_ff.car_offset < $signed(OFS_W'(LANE_WIDTH * (l + 1))));
      end

      // ego lane
      if (in_ff.ego_offset < $signed(OFS_W'(LANE_WIDTH))) begin
         slot_in.own_lane = LANE_LEFT;
      end else if (in_ff.ego_offset < $signed(OFS_W'(2 * LANE_WIDTH))) begin
         slot_in.own_lane = LANE_MIDDLE;
      end else begin
         slot_in.own_lane = LANE_RIGHT;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         slot_valid_ff <= 1'b0;
      end else begin
         in_valid_ff   <= in_valid_in;
         slot_valid_ff <= slot_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && in_free) begin
         in_ff <= req_item;
      end
      if (in_go) begin
         slot_ff <= slot_in;
      end
   end

   assign slot_valid = slot_valid_ff;
   assign slot       = slot_ff;

endmodule

@@ sv/lgt_lanes.sv @@
// lgt_lanes: per-lane nearest gap registers, frame result and output register
// depends on lgt_pkg; takes slots from lgt_dist

module lgt_lanes (
   input  logic                clock,
   input  logic                reset,
   input  lgt_pkg::csr_type    csr,
   input  logic                slot_valid,
   input  lgt_pkg::slot_type   slot,
   output logic                slot_take,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lgt_pkg::result_type rsp_result
);
   import lgt_pkg::*;

   logic [LANE_COUNT-1:0][POS_W-1:0] ahead_ff, ahead_in, ahead_base;
   logic [LANE_COUNT-1:0][POS_W-1:0] behind_ff, behind_in, behind_base;
   logic [LANE_COUNT-1:0][SPD_W-1:0] speed_ff, speed_in, speed_base;
   logic [LANE_COUNT-1:0]            lane_free;
   logic                             rsp_valid_ff, rsp_valid_in;
   result_type                       rsp_ff, rsp_in;
   logic                             out_free;

   // a slot without a frame end never waits on the output
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign slot_take    = slot_valid && (!slot.last || out_free);
   assign rsp_valid_in = (slot_take && slot.last) ? 1'b1
                       : (out_free ? 1'b0 : rsp_valid_ff);

   // minimum update, strict improvement only
   always_comb begin
      for (int l = 0; l < LANE_COUNT; l++) begin
         ahead_base[l]  = slot.first ? csr.track_length : ahead_ff[l];
         behind_base[l] = slot.first ? csr.track_length : behind_ff[l];
         speed_base[l]  = slot.first ? csr.speed_limit  : speed_ff[l];
         ahead_in[l]    = ahead_base[l];
         behind_in[l]   = behind_base[l];
         speed_in[l]    = speed_base[l];
         if (slot.hit[l]) begin
            if (slot.ahead) begin
               if (slot.gap < ahead_base[l]) begin
                  ahead_in[l] = slot.gap;
                  speed_in[l] = slot.speed;
               end
            end else if (slot.gap < behind_base[l]) begin
               behind_in[l] = slot.gap;
            end
         end
         lane_free[l] = (ahead_in[l] > csr.lane_change_gap)
                     && (behind_in[l] > csr.lane_change_gap);
      end
   end

   // frame result
   always_comb begin
      rsp_in             = '0;
      rsp_in.ahead_gap   = ahead_in;
      rsp_in.behind_gap  = behind_in;
      rsp_in.ahead_speed = speed_in;
      rsp_in.own_lane    = slot.own_lane;
      unique case (slot.own_lane)
         LANE_LEFT: begin
            rsp_in.move_left_ok  = 1'b0;
            rsp_in.move_right_ok = lane_free[1];
         end
         LANE_MIDDLE: begin
            rsp_in.move_left_ok  = lane_free[0];
            rsp_in.move_right_ok = lane_free[2];
         end
         LANE_RIGHT: begin
            rsp_in.move_left_ok  = lane_free[1];
            rsp_in.move_right_ok = 1'b0;
         end
         default: begin
            rsp_in.move_left_ok  = 1'b0;
            rsp_in.move_right_ok = 1'b0;
         end
      endcase
   end

   // lane state and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < LANE_COUNT; l++) begin
            ahead_ff[l]  <= TRACK_LENGTH_RST;
            behind_ff[l] <= TRACK_LENGTH_RST;
            speed_ff[l]  <= SPEED_LIMIT_RST;
         end
         rsp_valid_ff <= 1'b0;
      end else begin
         if (slot_take) begin
            ahead_ff  <= ahead_in;
            behind_ff <= behind_in;
            speed_ff  <= speed_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload
   always_ff @(posedge clock) begin
      if (slot_take && slot.last) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

`ifndef SYNTHESIS
   a_frame_end_emits: assert property (@(posedge clock) disable iff (reset)
      slot_take && slot.last |=> rsp_valid_ff)
      else $error("frame end consumed without a result beat");

   a_clear_bounds_gap: assert property (@(posedge clock) disable iff (reset)
      slot_take && slot.first |=> ahead_ff[0] <= $past(csr.track_length)
         && behind_ff[0] <= $past(csr.track_length))
      else $error("lane 0 minimum above track length after frame start");

   a_no_left_of_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.move_left_ok |-> rsp_ff.own_lane != LANE_LEFT)
      else $error("left change granted from the left lane");

   a_no_right_of_right: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.move_right_ok |-> rsp_ff.own_lane != LANE_RIGHT)
      else $error("right change granted from the right lane");
`endif

endmodule

@@ sv/lane_gap_tracker_top.sv @@
// lane_gap_tracker_top: top level, configuration registers and port mapping
// depends on lgt_pkg, lgt_dist and lgt_lanes

// The tracker takes one beat per clock with no bubbles while req_stall is low:
// each vehicle beat goes through an input register, a ring distance register
// and the per-lane minimum update, and a frame end writes its result into the
// output register. The rate is set by the per-lane minimum registers, which
// compare and update once per cycle. The output register holds a stalled result
// while beats without a frame end keep flowing; a frame end waits only for that
// register. Register writes are taken at once and reach the lane minima at
// the next first_of_frame; write them while no beat is in flight.

module lane_gap_tracker_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write,
   input  logic [lgt_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lgt_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [lgt_pkg::POS_W-1:0]        req_ego_position,
   input  logic signed [lgt_pkg::OFS_W-1:0] req_ego_offset,
   input  logic [lgt_pkg::POS_W-1:0]        req_car_position,
   input  logic signed [lgt_pkg::OFS_W-1:0] req_car_offset,
   input  logic [lgt_pkg::SPD_W-1:0]        req_car_speed,
   input  logic                             req_car_present,
   input  logic                             req_first_of_frame,
   input  logic                             req_last_of_frame,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [lgt_pkg::POS_W-1:0]        rsp_ahead_gap_left,
   output logic [lgt_pkg::POS_W-1:0]        rsp_ahead_gap_middle,
   output logic [lgt_pkg::POS_W-1:0]        rsp_ahead_gap_right,
   output logic [lgt_pkg::POS_W-1:0]        rsp_behind_gap_left,
   output logic [lgt_pkg::POS_W-1:0]        rsp_behind_gap_middle,
   output logic [lgt_pkg::POS_W-1:0]        rsp_behind_gap_right,
   output logic [lgt_pkg::SPD_W-1:0]        rsp_ahead_speed_left,
   output logic [lgt_pkg::SPD_W-1:0]        rsp_ahead_speed_middle,
   output logic [lgt_pkg::SPD_W-1:0]        rsp_ahead_speed_right,
   output logic [lgt_pkg::LANE_IDX_W-1:0]   rsp_own_lane,
   output logic                             rsp_move_left_ok,
   output logic                             rsp_move_right_ok
);
   import lgt_pkg::*;

   csr_type    csr_ff, csr_in;
   item_type   req_item;
   logic       slot_valid, slot_take;
   slot_type   slot;
   result_type rsp_result;

   // configuration register decode
   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_TRACK_LENGTH:    csr_in.track_length    = csr_wdata[POS_W-1:0];
            CSR_LANE_CHANGE_GAP: csr_in.lane_change_gap = csr_wdata[POS_W-1:0];
            CSR_SPEED_LIMIT:     csr_in.speed_limit     = csr_wdata[SPD_W-1:0];
            default:             csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.track_length    <= TRACK_LENGTH_RST;
         csr_ff.lane_change_gap <= LANE_CHANGE_GAP_RST;
         csr_ff.speed_limit     <= SPEED_LIMIT_RST;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // input beat gathering
   always_comb begin
      req_item.ego_position   = req_ego_position;
      req_item.ego_offset     = req_ego_offset;
      req_item.car_position   = req_car_position;
      req_item.car_offset     = req_car_offset;
      req_item.car_speed      = req_car_speed;
      req_item.car_present    = req_car_present;
      req_item.first_of_frame = req_first_of_frame;
      req_item.last_of_frame  = req_last_of_frame;
   end

   lgt_dist u_dist (
      .clock        (clock),
      .reset        (reset),
      .track_length (csr_ff.track_length),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_item     (req_item),
      .slot_valid   (slot_valid),
      .slot         (slot),
      .slot_take    (slot_take)
   );

   lgt_lanes u_lanes (
      .clock      (clock),
      .reset      (reset),
      .csr        (csr_ff),
      .slot_valid (slot_valid),
      .slot       (slot),
      .slot_take  (slot_take),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   // result beat fields
   assign rsp_ahead_gap_left     = rsp_result.ahead_gap[0];
   assign rsp_ahead_gap_middle   = rsp_result.ahead_gap[1];
   assign rsp_ahead_gap_right    = rsp_result.ahead_gap[2];
   assign rsp_behind_gap_left    = rsp_result.behind_gap[0];
   assign rsp_behind_gap_middle  = rsp_result.behind_gap[1];
   assign rsp_behind_gap_right   = rsp_result.behind_gap[2];
   assign rsp_ahead_speed_left   = rsp_result.ahead_speed[0];
   assign rsp_ahead_speed_middle = rsp_result.ahead_speed[1];
   assign rsp_ahead_speed_right  = rsp_result.ahead_speed[2];
   assign rsp_own_lane           = rsp_result.own_lane;
   assign rsp_move_left_ok       = rsp_result.move_left_ok;
   assign rsp_move_right_ok      = rsp_result.move_right_ok;

endmodule

@@ dv/lgt_gap_checker.sv @@
// lgt_gap_checker: watches the csr, req_ and rsp_ ports of the lane gap tracker,
// predicts each frame result and compares it field by field
// depends on lgt_pkg; instantiated by lane_gap_tracker_top_tb

module lgt_gap_checker
   import lgt_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [POS_W-1:0]        req_ego_position,
   input  logic signed [OFS_W-1:0] req_ego_offset,
   input  logic [POS_W-1:0]        req_car_position,
   input  logic signed [OFS_W-1:0] req_car_offset,
   input  logic [SPD_W-1:0]        req_car_speed,
   input  logic                    req_car_present,
   input  logic                    req_first_of_frame,
   input  logic                    req_last_of_frame,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [POS_W-1:0]        rsp_ahead_gap_left,
   input  logic [POS_W-1:0]        rsp_ahead_gap_middle,
   input  logic [POS_W-1:0]        rsp_ahead_gap_right,
   input  logic [POS_W-1:0]        rsp_behind_gap_left,
   input  logic [POS_W-1:0]        rsp_behind_gap_middle,
   input  logic [POS_W-1:0]        rsp_behind_gap_right,
   input  logic [SPD_W-1:0]        rsp_ahead_speed_left,
   input  logic [SPD_W-1:0]        rsp_ahead_speed_middle,
   input  logic [SPD_W-1:0]        rsp_ahead_speed_right,
   input  logic [LANE_IDX_W-1:0]   rsp_own_lane,
   input  logic                    rsp_move_left_ok,
   input  logic                    rsp_move_right_ok,
   output int                      fail_count,
   output int                      pending
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PRINT_CAP = 60;

   // mirrored registers and per-lane minima
   csr_type          regs;
   logic [POS_W-1:0] min_ahead  [LANE_COUNT];
   logic [POS_W-1:0] min_behind [LANE_COUNT];
   logic [SPD_W-1:0] lead_speed [LANE_COUNT];

   result_type frame_results_due [$];

   string lane_name [LANE_COUNT] = '{"left", "middle", "right"};

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic report(input string what, input longint got, input longint want);
      if (fail_count < PRINT_CAP)
         $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic void clear_lanes();
      for (int l = 0; l < LANE_COUNT; l++) begin
         min_ahead[l]  = regs.track_length;
         min_behind[l] = regs.track_length;
         lead_speed[l] = regs.speed_limit;
      end
   endfunction

   // place the car the shorter way round; a tie takes the wrapped way
   function automatic void place_car(input logic [POS_W-1:0] ego_pos,
                                     input logic [POS_W-1:0] car_pos,
                                     output logic ahead, output longint gap);
      longint e, c, len, direct, wrapped;
      e = ego_pos;
      c = car_pos;
      len = regs.track_length;
      direct = (c >= e) ? c - e : e - c;
      wrapped = (direct >= len) ? direct - len : len - direct;
      if (wrapped <= direct) begin
         if (c <= e) c += len;
         else e += len;
      end
      ahead = (c >= e);
      gap = ahead ? c - e : e - c;
   endfunction

   function automatic logic lane_open(input int l);
      return min_ahead[l] > regs.lane_change_gap && min_behind[l] > regs.lane_change_gap;
   endfunction

   // fold one accepted beat into the minima, queue a result on frame end
   function automatic void fold_beat();
      logic       ahead;
      longint     gap;
      int         ofs;
      int         ego_ofs;
      result_type want;
      if (req_first_of_frame) clear_lanes();
      if (req_car_present) begin
         place_car(req_ego_position, req_car_position, ahead, gap);
         ofs = req_car_offset;
         for (int l = 0; l < LANE_COUNT; l++) begin
            if (ofs > LANE_WIDTH * l && ofs < LANE_WIDTH * (l + 1)) begin
               if (ahead) begin
                  if (gap < min_ahead[l]) begin
                     min_ahead[l]  = gap[POS_W-1:0];
                     lead_speed[l] = req_car_speed;
                  end
               end else if (gap < min_behind[l]) begin
                  min_behind[l] = gap[POS_W-1:0];
               end
            end
         end
      end
      if (req_last_of_frame) begin
         ego_ofs = req_ego_offset;
         for (int l = 0; l < LANE_COUNT; l++) begin
            want.ahead_gap[l]   = min_ahead[l];
            want.behind_gap[l]  = min_behind[l];
            want.ahead_speed[l] = lead_speed[l];
         end
         if (ego_ofs < LANE_WIDTH) want.own_lane = LANE_LEFT;
         else if (ego_ofs < 2 * LANE_WIDTH) want.own_lane = LANE_MIDDLE;
         else want.own_lane = LANE_RIGHT;
         want.move_left_ok  = (want.own_lane != LANE_LEFT) && lane_open(want.own_lane - 1);
         want.move_right_ok = (want.own_lane != LANE_RIGHT) && lane_open(want.own_lane + 1);
         frame_results_due = {frame_results_due, want};
      end
   endfunction

   // compare one accepted result beat with the oldest prediction
   task automatic check_result();
      result_type got, want;
      got.ahead_gap   = {rsp_ahead_gap_right, rsp_ahead_gap_middle, rsp_ahead_gap_left};
      got.behind_gap  = {rsp_behind_gap_right, rsp_behind_gap_middle, rsp_behind_gap_left};
      got.ahead_speed = {rsp_ahead_speed_right, rsp_ahead_speed_middle, rsp_ahead_speed_left};
      got.own_lane      = rsp_own_lane;
      got.move_left_ok  = rsp_move_left_ok;
      got.move_right_ok = rsp_move_right_ok;
      if (frame_results_due.size() == 0) begin
         report("result beat with no frame end pending", 1, 0);
         return;
      end
      want = frame_results_due.pop_front();
      for (int l = 0; l < LANE_COUNT; l++) begin
         if (got.ahead_gap[l] !== want.ahead_gap[l])
            report({"ahead_gap_", lane_name[l]}, got.ahead_gap[l], want.ahead_gap[l]);
         if (got.behind_gap[l] !== want.behind_gap[l])
            report({"behind_gap_", lane_name[l]}, got.behind_gap[l], want.behind_gap[l]);
         if (got.ahead_speed[l] !== want.ahead_speed[l])
            report({"ahead_speed_", lane_name[l]}, got.ahead_speed[l], want.ahead_speed[l]);
      end
      if (got.own_lane !== want.own_lane)
         report("own_lane", got.own_lane, want.own_lane);
      if (got.move_left_ok !== want.move_left_ok)
         report("move_left_ok", got.move_left_ok, want.move_left_ok);
      if (got.move_right_ok !== want.move_right_ok)
         report("move_right_ok", got.move_right_ok, want.move_right_ok);
   endtask

   // everything sampled at the rising edge, before the block updates
   always @(posedge clock) begin
      if (reset) begin
         regs.track_length    = TRACK_LENGTH_RST;
         regs.lane_change_gap = LANE_CHANGE_GAP_RST;
         regs.speed_limit     = SPEED_LIMIT_RST;
         clear_lanes();
         frame_results_due.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_TRACK_LENGTH:    regs.track_length    = csr_wdata;
               CSR_LANE_CHANGE_GAP: regs.lane_change_gap = csr_wdata;
               CSR_SPEED_LIMIT:     regs.speed_limit     = csr_wdata[SPD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) fold_beat();
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) check_result();
      end
      pending = frame_results_due.size();
   end

endmodule

@@ dv/lane_gap_tracker_top_tb.sv @@
// lane_gap_tracker_top_tb: clock, reset, register setup and beat stimulus
// for the lane gap tracker; depends on lgt_pkg, lane_gap_tracker_top, lgt_gap_checker

module lane_gap_tracker_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import lgt_pkg::*;

   localparam int                   LIMIT_CYCLES  = 400000;
   localparam int                   SETTLE_CYCLES = 10;
   localparam int                   PHASES        = 7;
   localparam int                   BEATS_PER_PHASE = 158;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED    = 2'd3;
   localparam logic [POS_W-1:0]     POS_MAX       = '1;
   localparam logic [SPD_W-1:0]     SPD_MAX       = '1;

   logic                    clock;
   logic                    reset;
   logic                    csr_write;
   logic [CSR_IDX_W-1:0]    csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;
   logic                    req_valid;
   logic                    req_stall;
   logic [POS_W-1:0]        req_ego_position;
   logic signed [OFS_W-1:0] req_ego_offset;
   logic [POS_W-1:0]        req_car_position;
   logic signed [OFS_W-1:0] req_car_offset;
   logic [SPD_W-1:0]        req_car_speed;
   logic                    req_car_present;
   logic                    req_first_of_frame;
   logic                    req_last_of_frame;
   logic                    rsp_valid;
   logic                    rsp_stall;
   logic [POS_W-1:0]        rsp_ahead_gap_left;
   logic [POS_W-1:0]        rsp_ahead_gap_middle;
   logic [POS_W-1:0]        rsp_ahead_gap_right;
   logic [POS_W-1:0]        rsp_behind_gap_left;
   logic [POS_W-1:0]        rsp_behind_gap_middle;
   logic [POS_W-1:0]        rsp_behind_gap_right;
   logic [SPD_W-1:0]        rsp_ahead_speed_left;
   logic [SPD_W-1:0]        rsp_ahead_speed_middle;
   logic [SPD_W-1:0]        rsp_ahead_speed_right;
   logic [LANE_IDX_W-1:0]   rsp_own_lane;
   logic                    rsp_move_left_ok;
   logic                    rsp_move_right_ok;
   int                      fail_count;
   int                      pending;

   int     cycles;
   int     beats_sent;
   int     burst_left;
   longint cur_track;

   lane_gap_tracker_top dut (.*);

   lgt_gap_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
         $display("FAILURE");
         $finish;
      end
   end

   // receiver stall pattern: stretches of no stall, light, heavy and periodic
   initial begin
      int mode, span, k;
      rsp_stall = 1'b0;
      k = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 150);
         repeat (span) begin
            @(negedge clock);
            k++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= ((k % 7) < 3);
            endcase
         end
      end
   end

   // one beat on req_, held until taken; the sender sometimes idles between bursts
   task automatic send_beat(input logic [POS_W-1:0] ego_pos, input logic signed [OFS_W-1:0] ego_ofs,
                            input logic [POS_W-1:0] car_pos, input logic signed [OFS_W-1:0] car_ofs,
                            input logic [SPD_W-1:0] speed, input logic present,
                            input logic first, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      @(negedge clock);
      req_valid          <= 1'b1;
      req_ego_position   <= ego_pos;
      req_ego_offset     <= ego_ofs;
      req_car_position   <= car_pos;
      req_car_offset     <= car_ofs;
      req_car_speed      <= speed;
      req_car_present    <= present;
      req_first_of_frame <= first;
      req_last_of_frame  <= last;
      do @(posedge clock); while (req_stall);
      beats_sent++;
   endtask

   // stop sending, let every frame result out, then give the pipe time to empty
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] track, input logic [CSR_DATA_W-1:0] gap,
                            input logic [CSR_DATA_W-1:0] limit, input logic poke_unused);
      csr_put(CSR_TRACK_LENGTH, track);
      csr_put(CSR_LANE_CHANGE_GAP, gap);
      csr_put(CSR_SPEED_LIMIT, limit);
      if (poke_unused) csr_put(CSR_UNUSED, $urandom);
      @(negedge clock);
      csr_write <= 1'b0;
      cur_track = track;
   endtask

   // mostly inside a lane, sometimes on a boundary, sometimes anywhere
   function automatic logic signed [OFS_W-1:0] lane_offset();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 15) return $urandom_range(1, 3 * LANE_WIDTH - 1);
      if (pick < 17) return LANE_WIDTH * $urandom_range(0, 3);
      if (pick < 18) return LANE_WIDTH * $urandom_range(0, 3) + $urandom_range(0, 2) - 1;
      return $urandom;
   endfunction

   // one vehicle beat, usually within reach of the ego vehicle on the ring
   task automatic random_beat(input logic first, input logic last);
      logic [POS_W-1:0] ego_pos, car_pos;
      longint           reach, delta, pos;
      if ($urandom_range(0, 4) == 0) ego_pos = $urandom;
      else ego_pos = $urandom_range(0, cur_track - 1);
      if ($urandom_range(0, 3) == 0) begin
         car_pos = $urandom;
      end else begin
         reach = (cur_track < 16000) ? cur_track : 16000;
         delta = longint'($urandom_range(0, 2 * reach)) - reach;
         pos = (longint'(ego_pos) + delta) % cur_track;
         if (pos < 0) pos += cur_track;
         car_pos = pos[POS_W-1:0];
      end
      send_beat(ego_pos, lane_offset(), car_pos, lane_offset(), $urandom,
                $urandom_range(0, 9) != 0, first, last);
   endtask

   // mostly whole frames, then frames with marks missing, then noise
   task automatic random_frame();
      int kind, len;
      kind = $urandom_range(0, 99);
      len = $urandom_range(1, 10);
      if (kind < 75) begin
         for (int i = 0; i < len; i++) random_beat(i == 0, i == len - 1);
      end else if (kind < 85) begin
         for (int i = 0; i < len; i++) random_beat(i == 0, 1'b0);
      end else if (kind < 92) begin
         for (int i = 0; i < len; i++) random_beat(1'b0, i == len - 1);
      end else begin
         send_beat($urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom);
      end
   endtask

   // main sequence
   initial begin
      int target;
      reset              = 1'b1;
      csr_write          = 1'b0;
      csr_index          = CSR_TRACK_LENGTH;
      csr_wdata          = '0;
      req_valid          = 1'b0;
      req_ego_position   = '0;
      req_ego_offset     = '0;
      req_car_position   = '0;
      req_car_offset     = '0;
      req_car_speed      = '0;
      req_car_present    = 1'b0;
      req_first_of_frame = 1'b0;
      req_last_of_frame  = 1'b0;
      beats_sent = 0;
      burst_left = 0;
      cur_track  = TRACK_LENGTH_RST;
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: empty frame at reset values
      send_beat(0, 0, 0, 0, 0, 1'b0, 1'b1, 1'b1);
      // car ahead, car behind, an equal gap ahead keeps the first speed
      send_beat(1000, 300, 1100, 300, SPD_MAX, 1'b1, 1'b1, 1'b0);
      send_beat(1000, 300, 900, 300, 7, 1'b1, 1'b0, 1'b0);
      send_beat(1000, 300, 1100, 400, 0, 1'b1, 1'b0, 1'b0);
      // offsets on lane boundaries and out of the road match nothing
      send_beat(1000, 300, 1050, LANE_WIDTH, 5, 1'b1, 1'b0, 1'b0);
      send_beat(1000, 300, 1050, 0, 5, 1'b1, 1'b0, 1'b0);
      send_beat(1000, 300, 1050, 3 * LANE_WIDTH, 5, 1'b1, 1'b0, 1'b0);
      send_beat(1000, 300, 1050, -2048, 5, 1'b1, 1'b0, 1'b0);
      send_beat(1000, 300, 1050, 2047, 5, 1'b1, 1'b0, 1'b0);
      send_beat(1000, 300, 1050, 2 * LANE_WIDTH, 5, 1'b1, 1'b0, 1'b0);
      // wrapped the short way round, then equal positions
      send_beat(0, 300, TRACK_LENGTH_RST - 1, 100, 33, 1'b1, 1'b0, 1'b0);
      send_beat(1000, 300, 1000, 600, 44, 1'b1, 1'b0, 1'b0);
      // empty beat inside a frame, its vehicle fields ignored
      send_beat(1000, 300, POS_MAX, 300, SPD_MAX, 1'b0, 1'b0, 1'b0);
      send_beat(1000, 300, 0, 0, 0, 1'b0, 1'b0, 1'b1);
      // ego lane at its edges
      send_beat(0, -2048, 0, 0, 0, 1'b0, 1'b1, 1'b1);
      send_beat(0, LANE_WIDTH - 1, 0, 0, 0, 1'b0, 1'b1, 1'b1);
      send_beat(0, 2 * LANE_WIDTH - 1, 0, 0, 0, 1'b0, 1'b1, 1'b1);
      send_beat(0, 2 * LANE_WIDTH, 0, 0, 0, 1'b0, 1'b1, 1'b1);
      send_beat(0, 2047, 0, 0, 0, 1'b0, 1'b1, 1'b1);
      settle();

      // even ring: exact ties go the wrapped way, positions past the ring end
      configure(1000, 0, SPD_MAX, 1'b0);
      send_beat(100, 600, 600, 100, 9, 1'b1, 1'b1, 1'b0);
      send_beat(2000, 600, 2500, 100, 9, 1'b1, 1'b0, 1'b0);
      send_beat(POS_MAX, 600, 0, 100, 8, 1'b1, 1'b0, 1'b1);
      settle();

      // random phases, extremes first
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: configure(POS_MAX, 0, SPD_MAX, 1'b0);
            1: configure(1, POS_MAX, 0, 1'b1);
            2: configure($urandom_range(200, 4000), $urandom_range(0, 1500), $urandom, 1'b0);
            default: configure($urandom_range(4000, 600000), $urandom_range(0, 6000),
                               $urandom, 1'b0);
         endcase
         target = beats_sent + BEATS_PER_PHASE;
         while (beats_sent < target) random_frame();
         settle();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/lgt_pkg.sv
sv/lgt_dist.sv
sv/lgt_lanes.sv
sv/lane_gap_tracker_top.sv
dv/lgt_gap_checker.sv
dv/lane_gap_tracker_top_tb.sv
